// File: sv/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared constants for the convex polygon point test: default sizes and
// the opcodes of an input item.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 1024;
  localparam int unsigned DEF_COORD_BITS   = 31;
  localparam int unsigned MIN_VERTICES     = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// File: sv/point_in_convex_polygon.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon
// Holds a counter-clockwise convex polygon and tells whether a point lies
// inside it or on its boundary, by binary search over the fan from vertex 0.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): an item with opcode write stores
// (coord_x, coord_y) at vertex_index and gives no result.
// An item with opcode query gives one result item on the output channel
// (out_valid_o / out_ready_i), inside_res_o = 1 when the point is inside or
// on the edge of the polygon.
// A query runs a binary search over the vertex table. Each probe goes through
// address and dual-port table read, eight coordinate differences, four 32x32
// products, then the two cross-product signs. A query makes at most
// ceil(log2(vertex_count + 1)) probes before its result is registered, and
// stops early when a probe finds the point outside.
// Configuration channel (cfg_valid_i / cfg_ready_o) loads vertex_count; it is
// always ready. Values below 3 act as 3, above MAX_VERTICES as MAX_VERTICES.
// Reset clears the control state and sets vertex_count to 3; the vertex table
// is not cleared and must be written before it is queried.
// The result sits in an output register: while the receiver stalls the block
// still accepts the next item, and a query that finishes waits for the slot.
// ----------------------------------------------------------------------------
module point_in_convex_polygon #(
  parameter int unsigned MAX_VERTICES = pcp_pkg::DEF_MAX_VERTICES,
  parameter int unsigned COORD_BITS   = pcp_pkg::DEF_COORD_BITS,
  localparam int unsigned IDX_W = $clog2(MAX_VERTICES),
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CNT_W-1:0]             cfg_vertex_count_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [IDX_W-1:0]             vertex_index_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;
  localparam int unsigned LW = CNT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ORG  = 3'd1;
  localparam logic [2:0] S_ADR  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  // vertex table, {x, y} per entry
  logic [2*CB-1:0] vtx_mem [MAX_VERTICES];
  logic [2*CB-1:0] rdata_a_q, rdata_b_q;

  logic [2:0] state_q, state_d;

  logic [CNT_W-1:0] vcount_q;
  logic [CNT_W-1:0] cnt_q, cnt_sat;
  logic signed [LW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0] m_q, m_d;
  logic signed [CB-1:0] px_q, py_q, ox_q, oy_q;
  logic signed [DW-1:0] diff_q [8];
  logic signed [PW-1:0] prod_q [4];
  logic res_q, res_d;
  logic out_valid_q, out_res_q;

  logic in_acc, wr_en, rd_en, out_load;
  logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
  logic signed [LW:0] lohi_sum;
  logic [IDX_W-1:0] m_nxt, nx_nxt;
  logic [CNT_W-1:0] m_plus1;
  logic search_on;
  logic signed [CB-1:0] ax, ay, bx, by;
  logic signed [XW-1:0] edge_x, fan_x;
  logic signed [LW-1:0] m_ext;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_res_q;

  // slots beyond the table are dropped
  assign wr_en = in_acc && (opcode_i == pcp_pkg::OP_WRITE)
                 && ({1'b0, vertex_index_i} < (IDX_W + 1)'(MAX_VERTICES));

  always_comb begin
    if (vcount_q < CNT_W'(pcp_pkg::MIN_VERTICES)) begin
      cnt_sat = CNT_W'(pcp_pkg::MIN_VERTICES);
    end else if (vcount_q > CNT_W'(MAX_VERTICES)) begin
      cnt_sat = CNT_W'(MAX_VERTICES);
    end else begin
      cnt_sat = vcount_q;
    end
  end

  // midpoint and its successor with wrap to vertex 0
  assign search_on = (lo_q <= hi_q);
  assign lohi_sum  = (LW + 1)'(lo_q) + (LW + 1)'(hi_q);
  assign m_nxt     = lohi_sum[IDX_W:1];
  assign m_plus1   = CNT_W'(m_nxt) + CNT_W'(1);
  assign nx_nxt    = (m_plus1 == cnt_q) ? '0 : m_plus1[IDX_W-1:0];

  assign rd_en     = (in_acc && (opcode_i == pcp_pkg::OP_QUERY))
                     || ((state_q == S_ADR) && search_on);
  assign rd_addr_a = (state_q == S_IDLE) ? '0 : m_nxt;
  assign rd_addr_b = nx_nxt;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vtx_mem[vertex_index_i] <= {coord_x_i, coord_y_i};
    end
    if (rd_en) begin
      rdata_a_q <= vtx_mem[rd_addr_a];
      rdata_b_q <= vtx_mem[rd_addr_b];
    end
  end

  assign ax = rdata_a_q[2*CB-1:CB];
  assign ay = rdata_a_q[CB-1:0];
  assign bx = rdata_b_q[2*CB-1:CB];
  assign by = rdata_b_q[CB-1:0];

  assign edge_x = XW'(prod_q[0]) - XW'(prod_q[1]);
  assign fan_x  = XW'(prod_q[2]) - XW'(prod_q[3]);
  assign m_ext  = LW'(m_q);

  assign out_load = (state_q == S_RES) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    m_d     = m_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (opcode_i == pcp_pkg::OP_QUERY)) begin
          lo_d    = '0;
          hi_d    = LW'(cnt_sat) - LW'(1);
          state_d = S_ORG;
        end
      end
      S_ORG: begin
        state_d = S_ADR;
      end
      S_ADR: begin
        if (search_on) begin
          m_d     = m_nxt;
          state_d = S_RD;
        end else begin
          res_d   = 1'b1;
          state_d = S_RES;
        end
      end
      S_RD: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (edge_x[XW-1]) begin
          res_d   = 1'b0;
          state_d = S_RES;
        end else begin
          if (!fan_x[XW-1]) begin
            lo_d = m_ext + LW'(1);
          end else begin
            hi_d = m_ext - LW'(1);
          end
          state_d = S_ADR;
        end
      end
      S_RES: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= CNT_W'(pcp_pkg::MIN_VERTICES);
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_vertex_count_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    res_q <= res_d;
    if (out_load) begin
      out_res_q <= res_q;
    end
    if (in_acc && (opcode_i == pcp_pkg::OP_QUERY)) begin
      px_q  <= coord_x_i;
      py_q  <= coord_y_i;
      cnt_q <= cnt_sat;
    end
    if (state_q == S_ORG) begin
      ox_q <= ax;
      oy_q <= ay;
    end
    if (state_q == S_RD) begin
      diff_q[0] <= DW'(bx) - DW'(ax);
      diff_q[1] <= DW'(by) - DW'(ay);
      diff_q[2] <= DW'(px_q) - DW'(ax);
      diff_q[3] <= DW'(py_q) - DW'(ay);
      diff_q[4] <= DW'(ax) - DW'(ox_q);
      diff_q[5] <= DW'(ay) - DW'(oy_q);
      diff_q[6] <= DW'(px_q) - DW'(ox_q);
      diff_q[7] <= DW'(py_q) - DW'(oy_q);
    end
    if (state_q == S_MUL) begin
      prod_q[0] <= PW'(diff_q[0]) * PW'(diff_q[3]);
      prod_q[1] <= PW'(diff_q[2]) * PW'(diff_q[1]);
      prod_q[2] <= PW'(diff_q[4]) * PW'(diff_q[7]);
      prod_q[3] <= PW'(diff_q[6]) * PW'(diff_q[5]);
    end
  end

  // table writes only happen between queries, so reads never overlap them
  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_IDLE))
    else $error("vertex table written during a query");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ADR) && search_on) |-> (CNT_W'(m_nxt) < cnt_q))
    else $error("probe index beyond vertex count");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RES))
    else $error("result raised outside the result state");

  a_cmp_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |=> ((state_q == S_ADR) || (state_q == S_RES)))
    else $error("bad step after compare");

endmodule

// File: test/point_in_convex_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_convex_polygon_test
// Self-checking bench for the convex polygon point test. A short directed
// table (extreme triangle, clockwise and collinear tables) runs first, then
// phases that each set a vertex count, lay out a fresh polygon (save for 1024
// and 1025) and fire queries around it, checked against a fan search model.
// ----------------------------------------------------------------------------
module point_in_convex_polygon_test;

  localparam int unsigned NV = pcp_pkg::DEF_MAX_VERTICES;
  localparam int unsigned CW = pcp_pkg::DEF_COORD_BITS;
  localparam int unsigned IW = $clog2(NV);
  localparam int unsigned KW = $clog2(NV + 1);

  localparam int     TOTAL_ITEMS  = 1850;
  localparam int     DRAIN_CYCLES = 64;
  localparam int     CYCLE_LIMIT  = 600000;
  localparam longint COORD_MIN    = -1073741824;
  localparam longint COORD_MAX    = 1073741823;
  localparam real    TWO_PI       = 6.283185307179586;

  localparam logic [CW-1:0] C_LO = 31'h4000_0000;
  localparam logic [CW-1:0] C_HI = 31'h3FFF_FFFF;
  localparam logic [CW-1:0] C_M1 = 31'h7FFF_FFFF;

  typedef struct packed {
    logic          op;
    logic [IW-1:0] idx;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          typed;
    logic          res;
  } step_t;

  typedef struct packed {
    logic          is_in;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
  } verdict_t;

  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 cfg_valid_i        = 1'b0;
  logic                 cfg_ready_o;
  logic [KW-1:0]        cfg_vertex_count_i = '0;
  logic                 in_valid_i         = 1'b0;
  logic                 in_ready_o;
  logic                 opcode_i           = pcp_pkg::OP_WRITE;
  logic [IW-1:0]        vertex_index_i     = '0;
  logic signed [CW-1:0] coord_x_i          = '0;
  logic signed [CW-1:0] coord_y_i          = '0;
  logic                 out_valid_o;
  logic                 out_ready_i        = 1'b0;
  logic                 inside_res_o;

  point_in_convex_polygon dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .vertex_index_i     (vertex_index_i),
    .coord_x_i          (coord_x_i),
    .coord_y_i          (coord_y_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .inside_res_o       (inside_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the vertex table and the count register
  longint        vtx_x [NV];
  longint        vtx_y [NV];
  logic [KW-1:0] vcount_reg = KW'(pcp_pkg::MIN_VERTICES);
  verdict_t      verdict_q [$];

  // current polygon layout, used to aim the queries
  longint poly_cx, poly_cy, poly_r;

  bit tx_gaps   = 1'b1;
  bit rx_stalls = 1'b1;
  int n_items, n_queries, n_inside, n_errors, n_phases, n_clockwise, max_count;

  // extreme triangle, then clockwise and collinear tables
  step_t directed_steps [22] = '{
    '{pcp_pkg::OP_WRITE, 10'd0,    C_LO, C_LO, 1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'd1,    C_HI, C_LO, 1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'd2,    '0,   C_HI, 1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'h3FF,  C_LO, C_LO, 1'b1, 1'b1},
    '{pcp_pkg::OP_QUERY, 10'd0,    '0,   C_HI, 1'b1, 1'b1},
    '{pcp_pkg::OP_QUERY, 10'h3FF,  C_HI, C_HI, 1'b1, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    C_LO, C_HI, 1'b1, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    '0,   '0,   1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    '0,   C_LO, 1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    C_HI, C_LO, 1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'h3FF,  C_HI, C_HI, 1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'd512,  C_M1, C_M1, 1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'd1,    '0,   C_HI, 1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'd2,    C_HI, C_LO, 1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    '0,   '0,   1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    C_LO, C_LO, 1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    31'd100, -31'sd100, 1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'd1,    '0,   '0,   1'b0, 1'b0},
    '{pcp_pkg::OP_WRITE, 10'd2,    C_HI, C_HI, 1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    31'd5, 31'd5, 1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'd0,    31'd5, 31'd6, 1'b0, 1'b0},
    '{pcp_pkg::OP_QUERY, 10'h3FF,  C_HI, C_HI, 1'b0, 1'b0}
  };

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - bx * ay;
  endfunction

  function automatic int used_count();
    if (vcount_reg < pcp_pkg::MIN_VERTICES) return int'(pcp_pkg::MIN_VERTICES);
    if (vcount_reg > NV) return int'(NV);
    return int'(vcount_reg);
  endfunction

  // binary search over the wedges of the fan from vertex 0
  function automatic bit fan_search_inside(longint px, longint py);
    int     n, lo, hi, m, nx;
    longint ax, ay, bx, by;
    n  = used_count();
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      m  = (lo + hi) / 2;
      nx = (m + 1 == n) ? 0 : m + 1;
      ax = vtx_x[m];
      ay = vtx_y[m];
      bx = vtx_x[nx];
      by = vtx_y[nx];
      if (cross2(bx - ax, by - ay, px - ax, py - ay) < 0) return 1'b0;
      if (cross2(ax - vtx_x[0], ay - vtx_y[0], px - vtx_x[0], py - vtx_y[0]) >= 0) begin
        lo = m + 1;
      end else begin
        hi = m - 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic longint any_coord();
    return longint'($urandom_range(0, 32'h7FFF_FFFF)) - 2**30;
  endfunction

  function automatic void report_mismatch(string what, verdict_t v, int got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("[%0t] %s at (%0d, %0d): expected %0d, got %0d", $time, what,
               $signed(v.px), $signed(v.py), v.is_in, got);
    end
  endfunction

  task automatic put_item(logic op, int idx, longint x, longint y, bit typed, bit want);
    int       gap;
    verdict_t v;
    gap = tx_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    vertex_index_i <= idx[IW-1:0];
    coord_x_i      <= x[CW-1:0];
    coord_y_i      <= y[CW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    if (op == pcp_pkg::OP_WRITE) begin
      vtx_x[idx] = x;
      vtx_y[idx] = y;
    end else begin
      v.is_in = typed ? want : fan_search_inside(x, y);
      v.px    = x[CW-1:0];
      v.py    = y[CW-1:0];
      verdict_q.push_back(v);
      n_queries++;
      n_inside += v.is_in;
    end
  endtask

  // wait for the block to go quiet; writes leave no result to wait on
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_vertex_count(int value);
    settle();
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= KW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    vcount_reg = KW'(value);
  endtask

  // regular-ish polygon around a random center, now and then clockwise
  task automatic lay_polygon(int n);
    real    base, ang, dir;
    longint x, y;
    bit     cw;
    poly_cx = longint'($urandom_range(0, 2**30)) - 2**29;
    poly_cy = longint'($urandom_range(0, 2**30)) - 2**29;
    if (n > 64 || $urandom_range(0, 3) != 0) begin
      poly_r = $urandom_range(1 << 20, (1 << 29) - 1);
    end else begin
      poly_r = $urandom_range(8 * n, 4096);
    end
    cw   = ($urandom_range(0, 7) == 0);
    dir  = cw ? -TWO_PI : TWO_PI;
    base = TWO_PI * real'($urandom_range(0, 359)) / 360.0;
    n_clockwise += cw;
    for (int k = 0; k < n; k++) begin
      ang = base + dir * real'(k) / real'(n);
      x   = poly_cx + longint'($rtoi(real'(poly_r) * $cos(ang)));
      y   = poly_cy + longint'($rtoi(real'(poly_r) * $sin(ang)));
      put_item(pcp_pkg::OP_WRITE, k, x, y, 1'b0, 1'b0);
    end
  endtask

  task automatic put_query();
    int     n, k, nx, kind;
    longint qx, qy, span;
    n    = used_count();
    k    = $urandom_range(0, n - 1);
    nx   = (k + 1 == n) ? 0 : k + 1;
    kind = $urandom_range(0, 19);
    span = poly_r + poly_r / 4 + 2;
    if (kind < 8) begin
      qx = clamp_coord(poly_cx + longint'($urandom_range(0, 2 * span)) - span);
      qy = clamp_coord(poly_cy + longint'($urandom_range(0, 2 * span)) - span);
    end else if (kind < 11) begin
      qx = vtx_x[k];
      qy = vtx_y[k];
    end else if (kind < 14) begin
      // near the middle of an edge, on it when the halves are exact
      qx = (vtx_x[k] + vtx_x[nx]) >>> 1;
      qy = (vtx_y[k] + vtx_y[nx]) >>> 1;
    end else if (kind < 17) begin
      qx = clamp_coord(vtx_x[k] + longint'($urandom_range(0, 2)) - 1);
      qy = clamp_coord(vtx_y[k] + longint'($urandom_range(0, 2)) - 1);
    end else begin
      qx = any_coord();
      qy = any_coord();
    end
    put_item(pcp_pkg::OP_QUERY, $urandom_range(0, NV - 1), qx, qy, 1'b0, 1'b0);
  endtask

  initial begin : stimulus
    int plan_cfg [7];
    int phase, cfg_val, n, nq;
    plan_cfg = '{2047, 1024, 1025, 0, 1, 2, 3};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_steps[i]) begin
      put_item(directed_steps[i].op, directed_steps[i].idx,
               $signed(directed_steps[i].x), $signed(directed_steps[i].y),
               directed_steps[i].typed, directed_steps[i].res);
    end
    phase = 0;
    while (n_items < TOTAL_ITEMS) begin
      if (phase < 7) begin
        cfg_val = plan_cfg[phase];
      end else if ($urandom_range(0, 5) == 0) begin
        cfg_val = $urandom_range(25, 300);
      end else begin
        cfg_val = $urandom_range(3, 24);
      end
      load_vertex_count(cfg_val);
      tx_gaps   = (phase == 0) || ($urandom_range(0, 3) != 0);
      rx_stalls = (phase == 0) || ($urandom_range(0, 3) != 0);
      n = used_count();
      n_phases++;
      if (n > max_count) max_count = n;
      // 1024 and 1025 reuse the full table laid out for 2047
      if (phase != 1 && phase != 2) lay_polygon(n);
      nq = (n > 300) ? 40 : $urandom_range(15, 50);
      repeat (nq) begin
        if ($urandom_range(0, 24) == 0) begin
          put_item(pcp_pkg::OP_WRITE, $urandom_range(0, NV - 1), any_coord(), any_coord(),
                   1'b0, 1'b0);
        end else begin
          put_query();
        end
      end
      phase++;
    end
    settle();
    $display("%0d items sent, %0d point queries answered, %0d of them inside",
             n_items, n_queries, n_inside);
    $display("%0d vertex-count settings, up to %0d vertices, %0d clockwise tables",
             n_phases, max_count, n_clockwise);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_side
    int       stall;
    verdict_t v;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_stalls ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (verdict_q.size() == 0) begin
        v = '0;
        report_mismatch("result item with no query pending", v, inside_res_o);
      end else begin
        v = verdict_q.pop_front();
        if (inside_res_o !== v.is_in) report_mismatch("inside_res mismatch", v, inside_res_o);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d results outstanding",
             cycles, verdict_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
sv/pcp_pkg.sv
sv/point_in_convex_polygon.sv
test/point_in_convex_polygon_test.sv
